@@ design/tlb_lru_lookup_fill_unit_defines.svh @@
// Assertion macros for the TLB lookup/fill unit.
`ifndef TLB_LRU_LOOKUP_FILL_UNIT_DEFINES_SVH
`define TLB_LRU_LOOKUP_FILL_UNIT_DEFINES_SVH

// Clocked on clk_i, held off while rst_ni is low.
`define TLBLRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked on clk_i, checked during reset as well.
`define TLBLRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/tlblru_pkg.sv @@
// Shared constants, types and command codes of the TLB lookup/fill unit.
package tlblru_pkg;

  localparam int unsigned Entries    = 16;
  localparam int unsigned FrameCount = 4096;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned PageW   = 19;
  localparam int unsigned FrameW  = 12;
  localparam int unsigned StampW  = 32;
  localparam int unsigned VictimW = 4;
  localparam int unsigned HitW    = 1;

  // Stored frame width; truncating to it is the modulo by FrameCount.
  localparam int unsigned StoreW = $clog2(FrameCount);

  // Age key: valid bit above the stamp, so invalid entries are oldest.
  localparam int unsigned KeyW = StampW + 1;

  // Entries per first-level group of the victim search.
  localparam int unsigned GroupSize = 8;

  localparam int unsigned InDataW  = ((PageW + FrameW + StampW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((FrameW + VictimW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic capture;  // load the accepted item
    logic execute;  // apply the item to the entries and load the result
  } ctrl_t;

endpackage

@@ design/tlblru_victim.sv @@
// LRU victim search: registered per-group minimum, then a final pick.
module tlblru_victim #(
  parameter int unsigned Entries = tlblru_pkg::Entries
) (
  input  logic                                       clk_i,
  input  logic [Entries-1:0]                         valid_i,
  input  logic [Entries-1:0][tlblru_pkg::StampW-1:0] last_use_i,
  output logic [$clog2(Entries)-1:0]                 victim_idx_o
);

  localparam int unsigned IdxW      = $clog2(Entries);
  localparam int unsigned G         = tlblru_pkg::GroupSize;
  localparam int unsigned NumGroups = (Entries + G - 1) / G;
  localparam int unsigned KeyW      = tlblru_pkg::KeyW;

  // Invalid entries all share the lowest key, whatever their stale stamp.
  function automatic logic [KeyW-1:0] age_key(input logic                         vld,
                                              input logic [tlblru_pkg::StampW-1:0] stamp);
    logic [KeyW-1:0] key;
    key = vld ? {1'b1, stamp} : '0;
    return key;
  endfunction

  // Lower key wins; on a tie entry 0 wins, else the higher index.
  function automatic logic beats(input logic [KeyW-1:0] key_a, input logic [IdxW-1:0] idx_a,
                                 input logic [KeyW-1:0] key_b, input logic [IdxW-1:0] idx_b);
    logic res;
    if (key_a != key_b) begin
      res = key_a < key_b;
    end else begin
      res = (idx_a == '0) || ((idx_b != '0) && (idx_a > idx_b));
    end
    return res;
  endfunction

  logic [NumGroups-1:0][KeyW-1:0] grp_key_q;
  logic [NumGroups-1:0][IdxW-1:0] grp_idx_q;

  for (genvar g = 0; g < NumGroups; g++) begin : gen_group
    localparam int unsigned Base = g * G;
    localparam int unsigned Cnt  = ((Entries - Base) < G) ? (Entries - Base) : G;

    logic [KeyW-1:0] s1_key;
    logic [IdxW-1:0] s1_idx;

    always_comb begin
      s1_key = age_key(valid_i[Base], last_use_i[Base]);
      s1_idx = IdxW'(Base);
      for (int unsigned k = 1; k < Cnt; k++) begin
        if (beats(age_key(valid_i[Base+k], last_use_i[Base+k]), IdxW'(Base + k),
                  s1_key, s1_idx)) begin
          s1_key = age_key(valid_i[Base+k], last_use_i[Base+k]);
          s1_idx = IdxW'(Base + k);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      grp_key_q[g] <= s1_key;
      grp_idx_q[g] <= s1_idx;
    end
  end

  always_comb begin
    logic [KeyW-1:0] best_key;
    logic [IdxW-1:0] best_idx;
    best_key = grp_key_q[0];
    best_idx = grp_idx_q[0];
    for (int unsigned g = 1; g < NumGroups; g++) begin
      if (beats(grp_key_q[g], grp_idx_q[g], best_key, best_idx)) begin
        best_key = grp_key_q[g];
        best_idx = grp_idx_q[g];
      end
    end
    victim_idx_o = best_idx;
  end

endmodule

@@ design/tlblru_datapath.sv @@
// Entry storage, tag match, update logic and result register.
module tlblru_datapath #(
  parameter int unsigned Entries = tlblru_pkg::Entries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tlblru_pkg::ctrl_t               ctrl_i,
  input  logic [tlblru_pkg::CmdW-1:0]     cmd_i,
  input  logic [tlblru_pkg::PageW-1:0]    page_i,
  input  logic [tlblru_pkg::FrameW-1:0]   frame_i,
  input  logic [tlblru_pkg::StampW-1:0]   stamp_i,
  output logic                            hit_o,
  output logic [tlblru_pkg::FrameW-1:0]   frame_o,
  output logic [tlblru_pkg::VictimW-1:0]  victim_o
);

  localparam int unsigned IdxW = $clog2(Entries);

  // Item registers
  logic [tlblru_pkg::CmdW-1:0]   cmd_q;
  logic [tlblru_pkg::PageW-1:0]  page_q;
  logic [tlblru_pkg::FrameW-1:0] frame_q;
  logic [tlblru_pkg::StampW-1:0] stamp_q;

  // Entries
  logic [Entries-1:0]                         valid_q;
  logic [Entries-1:0][tlblru_pkg::PageW-1:0]  tag_q;
  logic [Entries-1:0][tlblru_pkg::StoreW-1:0] fstore_q;
  logic [Entries-1:0][tlblru_pkg::StampW-1:0] last_use_q;

  // Result registers
  logic                           hit_q, hit_d;
  logic [tlblru_pkg::FrameW-1:0]  frame_out_q, frame_out_d;
  logic [tlblru_pkg::VictimW-1:0] victim_q, victim_d;

  logic [Entries-1:0] match;
  logic               any_hit;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    victim_idx;

  tlblru_victim #(
    .Entries(Entries)
  ) u_victim (
    .clk_i       (clk_i),
    .valid_i     (valid_q),
    .last_use_i  (last_use_q),
    .victim_idx_o(victim_idx)
  );

  // Parallel tag compare; lowest matching index wins.
  always_comb begin
    for (int unsigned i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == page_q);
    end
    any_hit = |match;
    hit_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  // Result of the item in the execute cycle; zeros unless a hit or a fill.
  always_comb begin
    hit_d       = 1'b0;
    frame_out_d = '0;
    victim_d    = '0;
    unique case (cmd_q)
      tlblru_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          hit_d       = 1'b1;
          frame_out_d = tlblru_pkg::FrameW'(fstore_q[hit_idx]);
        end
      end
      tlblru_pkg::CMD_FILL: begin
        victim_d = tlblru_pkg::VictimW'(victim_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      page_q  <= page_i;
      frame_q <= frame_i;
      stamp_q <= stamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.execute) begin
      unique case (cmd_q)
        tlblru_pkg::CMD_FILL:  valid_q[victim_idx] <= 1'b1;
        tlblru_pkg::CMD_FLUSH: valid_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      hit_q       <= hit_d;
      frame_out_q <= frame_out_d;
      victim_q    <= victim_d;
      unique case (cmd_q)
        tlblru_pkg::CMD_LOOKUP: begin
          if (any_hit) begin
            last_use_q[hit_idx] <= stamp_q;
          end
        end
        tlblru_pkg::CMD_FILL: begin
          tag_q[victim_idx]      <= page_q;
          fstore_q[victim_idx]   <= tlblru_pkg::StoreW'(frame_q);
          last_use_q[victim_idx] <= stamp_q;
        end
        default: ;
      endcase
    end
  end

  assign hit_o    = hit_q;
  assign frame_o  = frame_out_q;
  assign victim_o = victim_q;

endmodule

@@ design/tlblru_ctrl.sv @@
// Controller: accept/execute sequencing and result valid flag.
module tlblru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlblru_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new item this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctrl_o.execute = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/tlb_lru_lookup_fill_unit.sv @@
// Top level of the fully associative TLB with LRU replacement.
//
//  channel  | dir | tdata (low bit first)                        | tuser
//  ---------+-----+----------------------------------------------+----------------
//  s_axis   | in  | page_number[18:0] frame_number[30:19]        | cmd[1:0]
//           |     | stamp[62:31], zero pad [63]                  |
//  m_axis   | out | frame_out[11:0] victim_index[15:12]          | hit[0]
//
// Steps per item: the idle state takes the item in, then the execute state
//   compares tags, picks the LRU victim from the group minima and updates the entry.
// The victim search keeps a registered per-group minimum refreshed every
//   cycle from the entries; the final pick runs in the execute cycle.
// Reset: clears all valid bits and the result flag; tag, frame and stamp
//   storage is not reset and is only read for valid entries.
// Stalls: a held result blocks the next item only in its execute cycle; a
//   new item is taken while the previous result still waits on m_axis.
module tlb_lru_lookup_fill_unit #(
  parameter int unsigned Entries = tlblru_pkg::Entries
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // page_number[18:0], frame_number[30:19], stamp[62:31]
  input  logic [tlblru_pkg::InDataW-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  logic [tlblru_pkg::CmdW-1:0]        s_axis_tuser,

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // frame_out[11:0], victim_index[15:12]
  output logic [tlblru_pkg::OutDataW-1:0]    m_axis_tdata,
  // hit[0]
  output logic [tlblru_pkg::HitW-1:0]        m_axis_tuser
);

  `include "tlb_lru_lookup_fill_unit_defines.svh"

  localparam int unsigned PageLo  = 0;
  localparam int unsigned FrameLo = PageLo + tlblru_pkg::PageW;
  localparam int unsigned StampLo = FrameLo + tlblru_pkg::FrameW;
  localparam int unsigned InUsed  = StampLo + tlblru_pkg::StampW;
  localparam int unsigned OutUsed = tlblru_pkg::FrameW + tlblru_pkg::VictimW;

  tlblru_pkg::ctrl_t ctrl;

  logic                           res_hit;
  logic [tlblru_pkg::FrameW-1:0]  res_frame;
  logic [tlblru_pkg::VictimW-1:0] res_victim;

  tlblru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctrl_o     (ctrl)
  );

  tlblru_datapath #(
    .Entries(Entries)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cmd_i   (s_axis_tuser),
    .page_i  (s_axis_tdata[FrameLo-1:PageLo]),
    .frame_i (s_axis_tdata[StampLo-1:FrameLo]),
    .stamp_i (s_axis_tdata[InUsed-1:StampLo]),
    .hit_o   (res_hit),
    .frame_o (res_frame),
    .victim_o(res_victim)
  );

  assign m_axis_tdata = tlblru_pkg::OutDataW'({res_victim, res_frame});
  assign m_axis_tuser = res_hit;

  // One item in flight: after an accept the input side is closed in the next cycle.
  `TLBLRU_ASSERT(a_single_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "item accepted while busy")
  // A hit never reports a victim.
  `TLBLRU_ASSERT(a_hit_no_victim, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[OutUsed-1:tlblru_pkg::FrameW] == '0), "hit with nonzero victim")
  // A new result follows an execute cycle, when the input side was closed.
  `TLBLRU_ASSERT(a_result_after_exec, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without execute")
  // No result is shown while in reset.
  `TLBLRU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

@@ tb/tlb_lru_lookup_fill_checker.sv @@
// Checker for the TLB lookup/fill unit: predicts every result and compares it on m_axis.
module tlb_lru_lookup_fill_checker
  import tlblru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // page_number[18:0], frame_number[30:19], stamp[62:31]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [CmdW-1:0]     s_axis_tuser,

  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // frame_out[11:0], victim_index[15:12]
  input  logic [OutDataW-1:0] m_axis_tdata,
  // hit[0]
  input  logic [HitW-1:0]     m_axis_tuser,

  output int                  fail_count_o,
  output int                  pending_o,
  output int                  result_count_o,
  output int                  hit_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               hit;
    logic [FrameW-1:0]  frame;
    logic [VictimW-1:0] victim;
  } xlate_result_t;

  // shadow copy of the entry array
  logic              tlb_valid [Entries];
  logic [PageW-1:0]  tlb_tag   [Entries];
  logic [StoreW-1:0] tlb_frame [Entries];
  logic [StampW-1:0] tlb_stamp [Entries];

  xlate_result_t expected_xlates [$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic xlate_result_t predict_xlate(logic [CmdW-1:0]   cmd,
                                                  logic [PageW-1:0]  page,
                                                  logic [FrameW-1:0] frame,
                                                  logic [StampW-1:0] stamp);
    xlate_result_t   res;
    int              lru;
    logic [KeyW-1:0] lru_age;
    logic [KeyW-1:0] age;
    res = '0;
    case (cmd)
      CMD_LOOKUP: begin
        // lowest-indexed valid match wins
        for (int i = 0; i < Entries; i++) begin
          if (!res.hit && tlb_valid[i] && tlb_tag[i] == page) begin
            tlb_stamp[i] = stamp;
            res.hit      = 1'b1;
            res.frame    = FrameW'(tlb_frame[i]);
          end
        end
      end
      CMD_FILL: begin
        // invalid entries are oldest; ties keep entry 0, else the highest index
        lru     = 0;
        lru_age = tlb_valid[0] ? {1'b1, tlb_stamp[0]} : '0;
        for (int i = Entries - 1; i > 0; i--) begin
          age = tlb_valid[i] ? {1'b1, tlb_stamp[i]} : '0;
          if (lru_age > age) begin
            lru     = i;
            lru_age = age;
          end
        end
        tlb_valid[lru] = 1'b1;
        tlb_tag[lru]   = page;
        tlb_frame[lru] = StoreW'(frame);
        tlb_stamp[lru] = stamp;
        res.victim     = VictimW'(lru);
      end
      CMD_FLUSH: begin
        for (int i = 0; i < Entries; i++) tlb_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xlate_result_t got;
    xlate_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) tlb_valid[i] = 1'b0;
      expected_xlates.delete();
      pending_o      <= 0;
      result_count_o <= 0;
      hit_count_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit    = m_axis_tuser[0];
        got.frame  = m_axis_tdata[FrameW-1:0];
        got.victim = m_axis_tdata[FrameW +: VictimW];
        if (expected_xlates.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(got), '0);
        end else begin
          want = expected_xlates.pop_front();
          if (got.hit !== want.hit)       report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.frame !== want.frame)   report_mismatch("frame_out", 32'(got.frame),
                                                          32'(want.frame));
          if (got.victim !== want.victim) report_mismatch("victim_index", 32'(got.victim),
                                                          32'(want.victim));
        end
        result_count_o <= result_count_o + 1;
        if (got.hit === 1'b1) hit_count_o <= hit_count_o + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_xlates.push_back(predict_xlate(s_axis_tuser,
                                                s_axis_tdata[PageW-1:0],
                                                s_axis_tdata[PageW +: FrameW],
                                                s_axis_tdata[PageW+FrameW +: StampW]));
      end
      pending_o <= expected_xlates.size();
    end
  end

endmodule

@@ tb/tb_tlb_lru_lookup_fill_unit.sv @@
// Testbench top for the TLB lookup/fill unit: stimulus, stall patterns and the verdict.
module tb_tlb_lru_lookup_fill_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlblru_pkg::*;

  // cmd code 3 is not an operation; the unit must answer it with all zeros
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam int RandomItems  = 850;
  localparam int QuietTail    = 150;  // last items run with no idling on either side
  localparam int PagePoolSize = 24;   // more pages than entries, so evictions happen

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;

  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // page_number[18:0], frame_number[30:19], stamp[62:31]
  logic [InDataW-1:0]  s_axis_tdata;
  // cmd[1:0]
  logic [CmdW-1:0]     s_axis_tuser;

  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // frame_out[11:0], victim_index[15:12]
  logic [OutDataW-1:0] m_axis_tdata;
  // hit[0]
  logic [HitW-1:0]     m_axis_tuser;

  int fail_count;
  int pending;
  int result_count;
  int hit_count;

  bit quiet_tail = 1'b0;

  int lookups_sent;
  int fills_sent;
  int flushes_sent;
  int unused_sent;

  logic [PageW-1:0]  page_pool [PagePoolSize];
  logic [StampW-1:0] stamp_clock;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tlb_lru_lookup_fill_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tlb_lru_lookup_fill_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .hit_count_o    (hit_count)
  );

  // Drive one item and hold it until the handshake. An optional idle burst goes
  // first; without one, tvalid simply stays high into the next item.
  task automatic issue(logic [CmdW-1:0] cmd, logic [PageW-1:0] page,
                       logic [FrameW-1:0] frame, logic [StampW-1:0] stamp);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(InDataW-PageW-FrameW-StampW){1'b0}}, stamp, frame, page};
    do @(posedge clk_i); while (!s_axis_tready);
    case (cmd)
      CMD_LOOKUP: lookups_sent++;
      CMD_FILL:   fills_sent++;
      CMD_FLUSH:  flushes_sent++;
      default:    unused_sent++;
    endcase
  endtask

  // Stop sending and wait until every outstanding item has produced its result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result side: random stall bursts, always ready during the quiet tail.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    int                r;
    logic [CmdW-1:0]   cmd;
    logic [PageW-1:0]  page;
    logic [StampW-1:0] stamp;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOOKUP;
    lookups_sent  = 0;
    fills_sent    = 0;
    flushes_sent  = 0;
    unused_sent   = 0;

    // page pool includes both extremes of the page number
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < PagePoolSize; i++) page_pool[i] = PageW'($urandom);

    // falling edge after time zero so every reset process sees it
    #1 rst_ni = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    issue(CMD_LOOKUP, '0, '0, 32'd1);          // lookup in an empty buffer misses
    issue(CMD_FILL, '1, '1, '1);               // all invalid: entry 0 is the victim
    issue(CMD_FILL, '0, '0, '0);               // highest invalid entry goes next
    issue(CMD_LOOKUP, '1, '0, 32'd5);          // hit, top frame value
    issue(CMD_FILL, '0, 12'hABC, 32'd7);       // duplicate page, no check on fill
    issue(CMD_LOOKUP, '0, '0, 32'd9);          // two matches: lower index wins
    issue(CmdUnused, '1, '1, '1);              // unused code changes nothing
    issue(CMD_FLUSH, '1, '1, '1);
    issue(CMD_LOOKUP, '1, '0, 32'd2);          // miss after flush
    // fill every entry with one stamp, then one more: the tie goes to entry 0
    for (int i = 0; i < Entries; i++) begin
      issue(CMD_FILL, PageW'(32'h100 + i), FrameW'(i), 32'd100);
    end
    issue(CMD_FILL, 19'h2AAAA, 12'h555, 32'd100);
    issue(CMD_LOOKUP, 19'h00100, '0, 32'd101); // evicted by the tie fill
    issue(CMD_LOOKUP, 19'h0010F, '0, 32'd102);

    // hold off until the directed results are all back
    drain();

    // ---- random part: mostly lookups and fills over a small page pool ----
    stamp_clock = 32'd1000;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) drain();
      if (n == RandomItems - QuietTail) quiet_tail = 1'b1;

      r = $urandom_range(0, 99);
      if (r < 60)      cmd = CMD_LOOKUP;
      else if (r < 97) cmd = CMD_FILL;
      else if (r < 99) cmd = CMD_FLUSH;
      else             cmd = CmdUnused;

      // pool pages give hits; random pages give misses and fresh tags
      page = ($urandom_range(0, 99) < 80) ? page_pool[$urandom_range(0, PagePoolSize - 1)]
                                          : PageW'($urandom);

      // stamps mostly advance slowly (steps of 0 produce ties), sometimes jump
      r = $urandom_range(0, 99);
      if (r < 80) begin
        stamp_clock = stamp_clock + $urandom_range(0, 3);
        stamp       = stamp_clock;
      end else if (r < 92) begin
        stamp = $urandom;
      end else if (r < 96) begin
        stamp = stamp_clock - $urandom_range(0, 8);
      end else begin
        stamp = $urandom_range(0, 1) ? '1 : '0;
      end

      issue(cmd, page, FrameW'($urandom), stamp);
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d lookups (%0d hits), %0d fills, %0d flushes, %0d unused codes",
             lookups_sent, hit_count, fills_sent, flushes_sent, unused_sent);
    $display("%0d results compared, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
